// ===== hw/rtl/contour_vertex_normals_assert.svh =====
// Assertion macros for the contour vertex normals block.
`ifndef CONTOUR_VERTEX_NORMALS_ASSERT_SVH
`define CONTOUR_VERTEX_NORMALS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CVN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("contour_vertex_normals: assertion failed");

// Next-cycle implication, disabled during reset.
`define CVN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("contour_vertex_normals: assertion failed");

`endif

// ===== hw/rtl/cvn_pkg.sv =====
// ----------------------------------------------------------------------------
// cvn_pkg
// Shared constants and types of the contour vertex normals block.
// ----------------------------------------------------------------------------
`default_nettype none

package cvn_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int SEEN_CAP   = MAX_POINTS + 2;
   localparam int SEEN_W     = $clog2(SEEN_CAP + 1);

   localparam int COORD_W    = 16;
   localparam int FRAC_BITS  = 14;
   localparam int OPND_W     = 18;   // edge deltas and normal sums
   localparam int MAG_W      = 17;
   localparam int EDGE_PRE   = 15;
   localparam int SUM_PRE    = 30 - FRAC_BITS;
   localparam int QUO_W      = 15;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   // request to the normalizing unit
   typedef struct packed {
      logic                     start;
      logic                     sum_mode;
      logic signed [OPND_W-1:0] a;
      logic signed [OPND_W-1:0] b;
   } uv_req_type;

   // unit vector back from the normalizing unit
   typedef struct packed {
      logic                      done;
      logic signed [COORD_W-1:0] ua;
      logic signed [COORD_W-1:0] ub;
   } uv_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/contour_vertex_normals.sv =====
// ----------------------------------------------------------------------------
// contour_vertex_normals
// Unit 2D vertex normals (Q1.14) of closed contours streamed point by point.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one contour point per request; set
//    req_end_of_slice on the last point of a contour. req_stall is high
//    while the block works on the previous request.
//  - Response channel (rsp_*): one vertex normal per response with its index
//    in the contour; rsp_last_of_slice marks the final normal of a contour.
//  - An ordinary point yields the normal of the previous vertex (none for
//    points 0 and 1); a closing point yields up to three normals.
//  - Each normal takes three vector normalizations in one shared unit, each
//    of 32 square-root steps and two 15-step divides, one after the other.
//    Points that produce no normal are taken every cycle.
//  - A stalled response holds in the output register; the next request is
//    taken once the last normal of the current one is loaded there.
//  - Reset (synchronous) clears the contour state and drops rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module contour_vertex_normals (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [cvn_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [cvn_pkg::COORD_W-1:0]   req_pos_y,
   input  logic                                 req_end_of_slice,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [cvn_pkg::COORD_W-1:0]   rsp_normal_x,
   output logic signed [cvn_pkg::COORD_W-1:0]   rsp_normal_y,
   output logic        [cvn_pkg::IDX_W-1:0]     rsp_point_index,
   output logic                                 rsp_last_of_slice
);
   import cvn_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EA   = 3'd1;
   localparam logic [2:0] S_EB   = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic                start_ff, start_in;
   point_type           first_ff, first_in, second_ff, second_in;
   point_type           older_ff, older_in, newest_ff, newest_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   point_type           job_prev_ff [3];
   point_type           job_prev_in [3];
   point_type           job_cur_ff  [3];
   point_type           job_cur_in  [3];
   point_type           job_next_ff [3];
   point_type           job_next_in [3];
   logic [IDX_W-1:0]    job_idx_ff  [3];
   logic [IDX_W-1:0]    job_idx_in  [3];
   logic                job_last_ff [3];
   logic                job_last_in [3];
   logic [1:0]          job_cnt_ff, job_cnt_in, job_sel_ff, job_sel_in;
   logic signed [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [COORD_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                out_free;
   point_type           pnt;
   point_type           cur_prev, cur_pnt, cur_next;
   uv_req_type          uv_req;
   uv_rsp_type          uv_rsp;
   logic [IDX_W-1:0]    idx_k, idx_km1;

   function automatic logic [IDX_W-1:0] clamp_idx(input logic [SEEN_W-1:0] order);
      if (order > SEEN_W'(MAX_POINTS - 1)) begin
         return IDX_W'(MAX_POINTS - 1);
      end
      return order[IDX_W-1:0];
   endfunction

   function automatic logic signed [OPND_W-1:0] sx(input logic signed [COORD_W-1:0] v);
      return {{(OPND_W-COORD_W){v[COORD_W-1]}}, v};
   endfunction

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pnt.x    = req_pos_x;
   assign pnt.y    = req_pos_y;
   assign idx_k    = clamp_idx(seen_ff);
   assign idx_km1  = clamp_idx(seen_ff - SEEN_W'(1));

   // operands of the current normalization
   assign cur_prev = job_prev_ff[job_sel_ff];
   assign cur_pnt  = job_cur_ff[job_sel_ff];
   assign cur_next = job_next_ff[job_sel_ff];

   always_comb begin
      uv_req.start    = start_ff;
      uv_req.sum_mode = (state_ff == S_SUM);
      unique case (state_ff)
         S_EA: begin
            uv_req.a = sx(cur_pnt.x) - sx(cur_prev.x);
            uv_req.b = sx(cur_pnt.y) - sx(cur_prev.y);
         end
         S_EB: begin
            uv_req.a = sx(cur_next.x) - sx(cur_pnt.x);
            uv_req.b = sx(cur_next.y) - sx(cur_pnt.y);
         end
         S_SUM: begin
            uv_req.a = sx(ay_ff) + sx(by_ff);
            uv_req.b = -(sx(ax_ff) + sx(bx_ff));
         end
         default: begin
            uv_req.a = '0;
            uv_req.b = '0;
         end
      endcase
   end

   cvn_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (uv_req),
      .rsp   (uv_rsp)
   );

   // contour tracking, job setup and normal sequencing
   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      first_in     = first_ff;
      second_in    = second_ff;
      older_in     = older_ff;
      newest_in    = newest_ff;
      seen_in      = seen_ff;
      job_prev_in  = job_prev_ff;
      job_cur_in   = job_cur_ff;
      job_next_in  = job_next_ff;
      job_idx_in   = job_idx_ff;
      job_last_in  = job_last_ff;
      job_cnt_in   = job_cnt_ff;
      job_sel_in   = job_sel_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               job_sel_in = '0;
               job_cnt_in = '0;
               if (!req_end_of_slice) begin
                  if (seen_ff == '0) begin
                     first_in = pnt;
                  end else if (seen_ff == SEEN_W'(1)) begin
                     second_in = pnt;
                  end else begin
                     job_prev_in[0] = older_ff;
                     job_cur_in[0]  = newest_ff;
                     job_next_in[0] = pnt;
                     job_idx_in[0]  = idx_km1;
                     job_last_in[0] = 1'b0;
                     job_cnt_in     = 2'd1;
                  end
                  older_in  = newest_ff;
                  newest_in = pnt;
                  if (seen_ff != SEEN_W'(SEEN_CAP)) begin
                     seen_in = seen_ff + SEEN_W'(1);
                  end
               end else begin
                  if (seen_ff == '0) begin
                     job_prev_in[0] = pnt;
                     job_cur_in[0]  = pnt;
                     job_next_in[0] = pnt;
                     job_idx_in[0]  = '0;
                     job_last_in[0] = 1'b1;
                     job_cnt_in     = 2'd1;
                  end else if (seen_ff == SEEN_W'(1)) begin
                     job_prev_in[0] = first_ff;
                     job_cur_in[0]  = pnt;
                     job_next_in[0] = first_ff;
                     job_idx_in[0]  = IDX_W'(1);
                     job_last_in[0] = 1'b0;
                     job_prev_in[1] = pnt;
                     job_cur_in[1]  = first_ff;
                     job_next_in[1] = pnt;
                     job_idx_in[1]  = '0;
                     job_last_in[1] = 1'b1;
                     job_cnt_in     = 2'd2;
                  end else begin
                     job_prev_in[0] = older_ff;
                     job_cur_in[0]  = newest_ff;
                     job_next_in[0] = pnt;
                     job_idx_in[0]  = idx_km1;
                     job_last_in[0] = 1'b0;
                     job_prev_in[1] = newest_ff;
                     job_cur_in[1]  = pnt;
                     job_next_in[1] = first_ff;
                     job_idx_in[1]  = idx_k;
                     job_last_in[1] = 1'b0;
                     job_prev_in[2] = pnt;
                     job_cur_in[2]  = first_ff;
                     job_next_in[2] = second_ff;
                     job_idx_in[2]  = '0;
                     job_last_in[2] = 1'b1;
                     job_cnt_in     = 2'd3;
                  end
                  first_in  = '0;
                  second_in = '0;
                  older_in  = '0;
                  newest_in = '0;
                  seen_in   = '0;
               end
               if (job_cnt_in != '0) begin
                  state_in = S_EA;
                  start_in = 1'b1;
               end
            end
         end
         S_EA: begin
            if (uv_rsp.done) begin
               ax_in    = uv_rsp.ua;
               ay_in    = uv_rsp.ub;
               state_in = S_EB;
               start_in = 1'b1;
            end
         end
         S_EB: begin
            if (uv_rsp.done) begin
               bx_in    = uv_rsp.ua;
               by_in    = uv_rsp.ub;
               state_in = S_SUM;
               start_in = 1'b1;
            end
         end
         S_SUM: begin
            if (uv_rsp.done) begin
               rx_in    = uv_rsp.ua;
               ry_in    = uv_rsp.ub;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = rx_ff;
               rsp_y_in     = ry_ff;
               rsp_idx_in   = job_idx_ff[job_sel_ff];
               rsp_last_in  = job_last_ff[job_sel_ff];
               if (job_sel_ff + 2'd1 == job_cnt_ff) begin
                  state_in = S_IDLE;
               end else begin
                  job_sel_in = job_sel_ff + 2'd1;
                  state_in   = S_EA;
                  start_in   = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= '0;
         second_ff    <= '0;
         older_ff     <= '0;
         newest_ff    <= '0;
         seen_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         older_ff     <= older_in;
         newest_ff    <= newest_in;
         seen_ff      <= seen_in;
      end
      job_prev_ff <= job_prev_in;
      job_cur_ff  <= job_cur_in;
      job_next_ff <= job_next_in;
      job_idx_ff  <= job_idx_in;
      job_last_ff <= job_last_in;
      job_cnt_ff  <= job_cnt_in;
      job_sel_ff  <= job_sel_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_normal_x      = rsp_x_ff;
   assign rsp_normal_y      = rsp_y_ff;
   assign rsp_point_index   = rsp_idx_ff;
   assign rsp_last_of_slice = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cvn_unit.sv =====
// ----------------------------------------------------------------------------
// cvn_unit
// Iterative vector normalizer: squares with one shared multiplier, takes an
// integer square root two bits per step, then divides each component by the
// length with a restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cvn_unit (
   input  logic              clock,
   input  logic              reset,
   input  cvn_pkg::uv_req_type req,
   output cvn_pkg::uv_rsp_type rsp
);
   import cvn_pkg::*;

   localparam logic [2:0] U_IDLE  = 3'd0;
   localparam logic [2:0] U_SQA   = 3'd1;
   localparam logic [2:0] U_SQB   = 3'd2;
   localparam logic [2:0] U_SQRT  = 3'd3;
   localparam logic [2:0] U_DLOAD = 3'd4;
   localparam logic [2:0] U_DIV   = 3'd5;
   localparam logic [2:0] U_DONE  = 3'd6;

   localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1 << FRAC_BITS);

   logic [2:0]        state_ff, state_in;
   logic              neg_a_ff, neg_a_in, neg_b_ff, neg_b_in;
   logic              sum_ff, sum_in;
   logic              sel_b_ff, sel_b_in;
   logic [MAG_W-1:0]  mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic [34:0]       acc_ff, acc_in;
   logic [63:0]       v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [31:0]       rem_ff, rem_in;
   logic [QUO_W-1:0]  nlo_ff, nlo_in, q_ff, q_in, qa_ff, qa_in, qb_ff, qb_in;
   logic [3:0]        cnt_ff, cnt_in;

   logic [MAG_W-1:0]  mul_op;
   logic [33:0]       prod;
   logic [63:0]       trial;
   logic [5:0]        sq_shift;
   logic [5:0]        div_shift;
   logic [MAG_W-1:0]  div_mag;
   logic [47:0]       num;
   logic [32:0]       div_t;
   logic [QUO_W-1:0]  qa_c, qb_c;
   logic [OPND_W-1:0] abs_a, abs_b;

   // shared multiplier
   assign mul_op = (state_ff == U_SQB) ? mag_b_ff : mag_a_ff;
   assign prod   = {{(34-MAG_W){1'b0}}, mul_op} * {{(34-MAG_W){1'b0}}, mul_op};

   assign trial     = res_ff + bit_ff;
   assign sq_shift  = sum_ff ? 6'(2 * SUM_PRE) : 6'(2 * EDGE_PRE);
   assign div_shift = sum_ff ? 6'(SUM_PRE + FRAC_BITS) : 6'(EDGE_PRE + FRAC_BITS);
   assign div_mag   = sel_b_ff ? mag_b_ff : mag_a_ff;
   assign num       = ({{(48-MAG_W){1'b0}}, div_mag} << div_shift)
                    + {17'b0, res_ff[31:1]};
   assign div_t     = {rem_ff, nlo_ff[QUO_W-1]};

   assign abs_a = req.a[OPND_W-1] ? -req.a : req.a;
   assign abs_b = req.b[OPND_W-1] ? -req.b : req.b;

   // sequencer
   always_comb begin
      state_in = state_ff;
      neg_a_in = neg_a_ff;
      neg_b_in = neg_b_ff;
      sum_in   = sum_ff;
      sel_b_in = sel_b_ff;
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      acc_in   = acc_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      nlo_in   = nlo_ff;
      q_in     = q_ff;
      qa_in    = qa_ff;
      qb_in    = qb_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               neg_a_in = req.a[OPND_W-1];
               neg_b_in = req.b[OPND_W-1];
               mag_a_in = abs_a[MAG_W-1:0];
               mag_b_in = abs_b[MAG_W-1:0];
               sum_in   = req.sum_mode;
               state_in = U_SQA;
            end
         end
         U_SQA: begin
            acc_in   = {1'b0, prod};
            state_in = U_SQB;
         end
         U_SQB: begin
            acc_in = acc_ff + {1'b0, prod};
            if (acc_in == '0) begin
               qa_in    = '0;
               qb_in    = '0;
               state_in = U_DONE;
            end else begin
               v_in     = {29'b0, acc_in} << sq_shift;
               res_in   = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               state_in = U_SQRT;
            end
         end
         U_SQRT: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               sel_b_in = 1'b0;
               state_in = U_DLOAD;
            end
         end
         U_DLOAD: begin
            rem_in   = num[46:QUO_W];
            nlo_in   = num[QUO_W-1:0];
            q_in     = '0;
            cnt_in   = '0;
            state_in = U_DIV;
         end
         U_DIV: begin
            if (div_t >= {1'b0, res_ff[31:0]}) begin
               rem_in = 32'(div_t - {1'b0, res_ff[31:0]});
               q_in   = {q_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = div_t[31:0];
               q_in   = {q_ff[QUO_W-2:0], 1'b0};
            end
            nlo_in = nlo_ff << 1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(QUO_W - 1)) begin
               if (!sel_b_ff) begin
                  qa_in    = q_in;
                  sel_b_in = 1'b1;
                  state_in = U_DLOAD;
               end else begin
                  qb_in    = q_in;
                  state_in = U_DONE;
               end
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
      sum_ff   <= sum_in;
      sel_b_ff <= sel_b_in;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      acc_ff   <= acc_in;
      v_ff     <= v_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      rem_ff   <= rem_in;
      nlo_ff   <= nlo_in;
      q_ff     <= q_in;
      qa_ff    <= qa_in;
      qb_ff    <= qb_in;
      cnt_ff   <= cnt_in;
   end

   // clamp to 1.0 and restore signs
   assign qa_c = (qa_ff > ONE_Q) ? ONE_Q : qa_ff;
   assign qb_c = (qb_ff > ONE_Q) ? ONE_Q : qb_ff;

   assign rsp.done = (state_ff == U_DONE);
   assign rsp.ua   = neg_a_ff ? -{1'b0, qa_c} : {1'b0, qa_c};
   assign rsp.ub   = neg_b_ff ? -{1'b0, qb_c} : {1'b0, qb_c};

endmodule

`default_nettype wire

// ===== hw/rtl/cvn_checker.sv =====
// ----------------------------------------------------------------------------
// cvn_checker
// Port-level checks of the contour vertex normals block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "contour_vertex_normals_assert.svh"

module cvn_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic signed [cvn_pkg::COORD_W-1:0] req_pos_x,
   input logic signed [cvn_pkg::COORD_W-1:0] req_pos_y,
   input logic                               req_end_of_slice,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [cvn_pkg::COORD_W-1:0] rsp_normal_x,
   input logic signed [cvn_pkg::COORD_W-1:0] rsp_normal_y,
   input logic        [cvn_pkg::IDX_W-1:0]   rsp_point_index,
   input logic                               rsp_last_of_slice
);
   import cvn_pkg::*;

   localparam logic signed [COORD_W-1:0] ONE_N = COORD_W'(1 << FRAC_BITS);

   // a stalled response keeps its value
   `CVN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_normal_x) && $stable(rsp_normal_y) && $stable(rsp_point_index) && $stable(rsp_last_of_slice))

   // a closing point always produces normals, so the block goes busy
   `CVN_ASSERT_NEXT(a_close_busy, clock, reset, req_valid && !req_stall && req_end_of_slice, req_stall)

   // the last normal of a contour is the one of point 0
   `CVN_ASSERT_NOW(a_last_idx0, clock, reset, rsp_valid && rsp_last_of_slice, rsp_point_index == '0)

   // components stay within one
   `CVN_ASSERT_NOW(a_unit_range, clock, reset, rsp_valid, rsp_normal_x <= ONE_N && rsp_normal_x >= -ONE_N && rsp_normal_y <= ONE_N && rsp_normal_y >= -ONE_N)

   logic unused_in;
   assign unused_in = ^{req_pos_x, req_pos_y};

endmodule

bind contour_vertex_normals cvn_checker u_cvn_checker (.*);

`default_nettype wire
